// File: hw/rtl/tdr_pkg.sv
// Shared types and constants for the table-driven DFA runner.
package tdr_pkg;

  localparam int StateCountDefault = 16;
  localparam int SymbolCount       = 256;
  localparam int SymbolWidth       = 8;
  localparam int StateWidth        = 4;
  localparam int CfgIndexWidth     = 1;

  typedef enum logic [1:0] {
    KindLoad    = 2'd0,
    KindStep    = 2'd1,
    KindRestart = 2'd2
  } kind_e;

  typedef enum logic [CfgIndexWidth-1:0] {
    CfgStartState  = 1'd0,
    CfgAcceptState = 1'd1
  } cfg_idx_e;

  // One transition table entry: a valid mark and the destination state.
  typedef struct packed {
    logic                  valid;
    logic [StateWidth-1:0] next;
  } entry_t;

endpackage

// File: hw/rtl/tdr_table.sv
// Transition table memory: one write port, one read port with registered data.
module tdr_table #(
  parameter int Depth     = tdr_pkg::StateCountDefault * tdr_pkg::SymbolCount,
  parameter int AddrWidth = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  tdr_pkg::entry_t      wdata_i,
  input  logic                 re_i,
  input  logic [AddrWidth-1:0] raddr_i,
  output tdr_pkg::entry_t      rdata_o
);

  tdr_pkg::entry_t mem [Depth];
  tdr_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/table_driven_dfa_runner_core.sv
// Table-driven DFA runner: transition table in memory, current state, and result register.
//
// Load requests write one transition and restart requests enter the start
// state; both are taken one per cycle while in_stall_o is low. For a step
// request the table is read at the current state in the cycle it is
// accepted, and the registered read data sets the next state, which is the
// address of the following step. After reset the block sweeps the whole table
// once to clear the valid marks and holds in_stall_o high until the sweep is
// done; configuration writes are taken throughout. A result waiting in the
// output register keeps the next request out only while a step or restart
// also waits in the stage before it.
module table_driven_dfa_runner_core #(
  parameter int StateCount = tdr_pkg::StateCountDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          in_kind_i,
  input  logic [tdr_pkg::StateWidth-1:0]      in_from_state_i,
  input  logic [tdr_pkg::SymbolWidth-1:0]     in_symbol_i,
  input  logic [tdr_pkg::StateWidth-1:0]      in_to_state_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [tdr_pkg::StateWidth-1:0]      out_state_now_o,
  output logic                                out_accepted_o,
  output logic                                out_dead_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tdr_pkg::CfgIndexWidth-1:0]   cfg_index_i,
  input  logic [tdr_pkg::StateWidth-1:0]      cfg_data_i
);

  localparam int SelWidth   = $clog2(StateCount);
  localparam int AddrWidth  = SelWidth + tdr_pkg::SymbolWidth;
  localparam int TableDepth = StateCount * tdr_pkg::SymbolCount;

  logic [tdr_pkg::StateWidth-1:0] start_q, accept_q;
  logic [tdr_pkg::StateWidth-1:0] cur_q;
  logic                           dead_q;
  logic                           clear_q;
  logic [AddrWidth-1:0]           clr_addr_q;
  logic                           s1_valid_q, s1_step_q;
  logic                           out_valid_q, out_accepted_q, out_dead_q;
  logic [tdr_pkg::StateWidth-1:0] out_state_q;

  logic                           in_acc, s1_adv, s1_fire;
  logic                           from_ok, to_ok, cur_ok, load_ok;
  logic                           tbl_we, tbl_re;
  logic [AddrWidth-1:0]           tbl_waddr, tbl_raddr;
  tdr_pkg::entry_t                tbl_wdata, tbl_rdata;
  logic                           step_dead, res_dead;
  logic [tdr_pkg::StateWidth-1:0] step_state, res_state;

  assign cfg_ready_o = 1'b1;

  assign s1_adv  = ~out_valid_q | ~out_stall_i;
  assign s1_fire = s1_valid_q & s1_adv;
  // A step in flight blocks the next request until its new state is known.
  assign in_stall_o = clear_q | (s1_valid_q & (s1_step_q | ~s1_adv));
  assign in_acc     = in_valid_i & ~in_stall_o;

  assign from_ok = 32'(in_from_state_i) < StateCount;
  assign to_ok   = 32'(in_to_state_i) < StateCount;
  assign cur_ok  = 32'(cur_q) < StateCount;
  assign load_ok = in_acc & (in_kind_i == tdr_pkg::KindLoad) & from_ok & to_ok;

  always_comb begin
    tbl_we    = clear_q | load_ok;
    tbl_waddr = clear_q ? clr_addr_q : {SelWidth'(in_from_state_i), in_symbol_i};
    tbl_wdata = '0;
    if (!clear_q) begin
      tbl_wdata.valid = 1'b1;
      tbl_wdata.next  = in_to_state_i;
    end
  end

  assign tbl_re    = in_acc & (in_kind_i == tdr_pkg::KindStep);
  assign tbl_raddr = {SelWidth'(cur_q), in_symbol_i};

  tdr_table #(
    .Depth     (TableDepth),
    .AddrWidth (AddrWidth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (tbl_re),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // The current state cannot change between a step's read and its resolution.
  always_comb begin
    step_dead  = dead_q | ~cur_ok | ~tbl_rdata.valid;
    step_state = step_dead ? cur_q : tbl_rdata.next;
    res_state  = s1_step_q ? step_state : cur_q;
    res_dead   = s1_step_q ? step_dead : dead_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q        <= '0;
      accept_q       <= '0;
      cur_q          <= '0;
      dead_q         <= 1'b0;
      clear_q        <= 1'b1;
      clr_addr_q     <= '0;
      s1_valid_q     <= 1'b0;
      s1_step_q      <= 1'b0;
      out_valid_q    <= 1'b0;
      out_state_q    <= '0;
      out_accepted_q <= 1'b0;
      out_dead_q     <= 1'b0;
    end else begin
      if (clear_q) begin
        clr_addr_q <= clr_addr_q + AddrWidth'(1);
        if (clr_addr_q == AddrWidth'(TableDepth - 1)) begin
          clear_q <= 1'b0;
        end
      end

      if (cfg_valid_i) begin
        case (cfg_index_i)
          tdr_pkg::CfgStartState:  start_q  <= cfg_data_i;
          tdr_pkg::CfgAcceptState: accept_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (in_acc && in_kind_i == tdr_pkg::KindRestart) begin
        cur_q  <= start_q;
        dead_q <= 1'b0;
      end else if (s1_fire && s1_step_q) begin
        cur_q  <= step_state;
        dead_q <= step_dead;
      end

      if (in_acc && (in_kind_i == tdr_pkg::KindStep || in_kind_i == tdr_pkg::KindRestart)) begin
        s1_valid_q <= 1'b1;
        s1_step_q  <= (in_kind_i == tdr_pkg::KindStep);
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end

      if (s1_fire) begin
        out_valid_q    <= 1'b1;
        out_state_q    <= res_state;
        out_dead_q     <= res_dead;
        out_accepted_q <= ~res_dead & (res_state == accept_q);
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_state_now_o = out_state_q;
  assign out_accepted_o  = out_accepted_q;
  assign out_dead_o      = out_dead_q;

endmodule

// File: hw/rtl/tdr_checker.sv
// Port-level assertions for the DFA runner, bound to the top level.
module tdr_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic [1:0]                          in_kind_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [tdr_pkg::StateWidth-1:0]      out_state_now_o,
  input logic                                out_accepted_o,
  input logic                                out_dead_o
);

  // The table clearing sweep holds off requests right after reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> in_stall_o)
    else $error("request channel open before the table was cleared");

  // A step needs its table read back before the next request can go in.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_kind_i == tdr_pkg::KindStep) |=> in_stall_o)
    else $error("request accepted right behind a step");

  // A dead machine never reports acceptance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_accepted_o && out_dead_o))
    else $error("result both accepted and dead");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_state_now_o)
      && $stable(out_accepted_o) && $stable(out_dead_o)))
    else $error("stalled result changed");

endmodule

bind table_driven_dfa_runner_core tdr_checker u_tdr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .in_kind_i       (in_kind_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .out_state_now_o (out_state_now_o),
  .out_accepted_o  (out_accepted_o),
  .out_dead_o      (out_dead_o)
);

// File: tb/tdr_result_checker.sv
`timescale 1ns / 100ps
// Checker for the DFA runner: tracks the machine from observed requests and compares its reports.
module tdr_result_checker #(
  parameter int StateCount = tdr_pkg::StateCountDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic [1:0]                          in_kind_i,
  input  logic [tdr_pkg::StateWidth-1:0]      in_from_state_i,
  input  logic [tdr_pkg::SymbolWidth-1:0]     in_symbol_i,
  input  logic [tdr_pkg::StateWidth-1:0]      in_to_state_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic [tdr_pkg::StateWidth-1:0]      out_state_now_i,
  input  logic                                out_accepted_i,
  input  logic                                out_dead_i,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic [tdr_pkg::CfgIndexWidth-1:0]   cfg_index_i,
  input  logic [tdr_pkg::StateWidth-1:0]      cfg_data_i,
  output int unsigned                         fail_count_o,
  output int unsigned                         pending_o
);
  import tdr_pkg::*;

  typedef struct packed {
    logic [StateWidth-1:0] state_now;
    logic                  accepted;
    logic                  dead;
  } dfa_report_t;

  localparam int Depth = StateCount * SymbolCount;

  logic [StateWidth-1:0] dest_of [Depth];
  bit                    has_dest [Depth];
  logic [StateWidth-1:0] state_q;
  logic [StateWidth-1:0] start_cfg;
  logic [StateWidth-1:0] accept_cfg;
  bit                    dead_q;
  dfa_report_t           predicted_reports [$];
  dfa_report_t           oldest;
  int unsigned           fails;
  int                    load_addr;

  function automatic dfa_report_t report_now();
    dfa_report_t r;
    r.state_now = state_q;
    r.accepted  = !dead_q && (state_q == accept_cfg);
    r.dead      = dead_q;
    return r;
  endfunction

  // The newest prediction goes to the back of the queue.
  function automatic void queue_report();
    predicted_reports.insert(predicted_reports.size(), report_now());
  endfunction

  // A dead machine holds its state until the next restart.
  function automatic void take_symbol(input logic [SymbolWidth-1:0] sym);
    int addr;
    if (!dead_q) begin
      if (int'(state_q) >= StateCount) begin
        dead_q = 1'b1;
      end else begin
        addr = int'(state_q) * SymbolCount + int'(sym);
        if (has_dest[addr]) begin
          state_q = dest_of[addr];
        end else begin
          dead_q = 1'b1;
        end
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    = '0;
      dead_q     = 1'b0;
      start_cfg  = '0;
      accept_cfg = '0;
      foreach (has_dest[a]) has_dest[a] = 1'b0;
      predicted_reports.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgStartState:  start_cfg = cfg_data_i;
          CfgAcceptState: accept_cfg = cfg_data_i;
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        case (in_kind_i)
          KindLoad: begin
            if (int'(in_from_state_i) < StateCount && int'(in_to_state_i) < StateCount) begin
              load_addr = int'(in_from_state_i) * SymbolCount + int'(in_symbol_i);
              dest_of[load_addr]  = in_to_state_i;
              has_dest[load_addr] = 1'b1;
            end
          end
          KindStep: begin
            take_symbol(in_symbol_i);
            queue_report();
          end
          KindRestart: begin
            state_q = start_cfg;
            dead_q  = 1'b0;
            queue_report();
          end
          default: ;
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        if (predicted_reports.size() == 0) begin
          $error("unexpected result: state_now %0d accepted %0d dead %0d",
                 out_state_now_i, out_accepted_i, out_dead_i);
          fails++;
        end else begin
          oldest = predicted_reports.pop_front();
          if (out_state_now_i !== oldest.state_now) begin
            $error("state_now mismatch: expected %0d, actual %0d",
                   oldest.state_now, out_state_now_i);
            fails++;
          end
          if (out_accepted_i !== oldest.accepted) begin
            $error("accepted mismatch: expected %0d, actual %0d",
                   oldest.accepted, out_accepted_i);
            fails++;
          end
          if (out_dead_i !== oldest.dead) begin
            $error("dead mismatch: expected %0d, actual %0d", oldest.dead, out_dead_i);
            fails++;
          end
        end
      end

      fail_count_o <= fails;
      pending_o    <= predicted_reports.size();
    end
  end

endmodule

// File: tb/tb_table_driven_dfa_runner_core.sv
`timescale 1ns / 100ps
// Top-level testbench for the DFA runner: clock, reset, request stimulus and the verdict.
module tb_table_driven_dfa_runner_core;
  import tdr_pkg::*;

  localparam int          StateCount  = StateCountDefault;
  localparam logic [1:0]  KindIgnored = 2'd3;
  localparam int unsigned RequestGoal = 1870;
  localparam int unsigned SettleCycles = 8;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid;
  logic                     in_stall;
  logic [1:0]               in_kind;
  logic [StateWidth-1:0]    in_from_state;
  logic [SymbolWidth-1:0]   in_symbol;
  logic [StateWidth-1:0]    in_to_state;
  logic                     out_valid;
  logic                     out_stall;
  logic [StateWidth-1:0]    out_state_now;
  logic                     out_accepted;
  logic                     out_dead;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [StateWidth-1:0]    cfg_data;
  int unsigned              fail_count;
  int unsigned              pending;

  bit                       no_gaps;
  bit                       stall_on;
  int unsigned              burst_left;
  int unsigned              requests_sent;
  logic [SymbolWidth-1:0]   alphabet [8];
  int unsigned              alpha_len;

  table_driven_dfa_runner_core #(
    .StateCount(StateCount)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .in_kind_i      (in_kind),
    .in_from_state_i(in_from_state),
    .in_symbol_i    (in_symbol),
    .in_to_state_i  (in_to_state),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_state_now_o(out_state_now),
    .out_accepted_o (out_accepted),
    .out_dead_o     (out_dead),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  tdr_result_checker #(
    .StateCount(StateCount)
  ) i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .in_kind_i      (in_kind),
    .in_from_state_i(in_from_state),
    .in_symbol_i    (in_symbol),
    .in_to_state_i  (in_to_state),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .out_state_now_i(out_state_now),
    .out_accepted_i (out_accepted),
    .out_dead_i     (out_dead),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Mostly short gaps, a few long ones.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(99);
    if (no_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // The receiver alternates between stall bursts and flow bursts.
  always @(posedge clk_i) begin
    if (burst_left == 0) begin
      stall_on   = !stall_on;
      burst_left = stall_on ? gap_len() : $urandom_range(1, 12);
    end
    if (burst_left != 0) begin
      burst_left--;
      out_stall <= stall_on;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send(input logic [1:0] kind, input logic [StateWidth-1:0] from,
                      input logic [SymbolWidth-1:0] sym, input logic [StateWidth-1:0] to);
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_from_state <= from;
    in_symbol     <= sym;
    in_to_state   <= to;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    if (kind != KindIgnored) requests_sent++;
  endtask

  // Loads leave no result behind, so drain keeps clocking after the last report.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic configure(input logic [StateWidth-1:0] start_st,
                           input logic [StateWidth-1:0] accept_st);
    cfg_valid <= 1'b1;
    cfg_index <= CfgStartState;
    cfg_data  <= start_st;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_index <= CfgAcceptState;
    cfg_data  <= accept_st;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [SymbolWidth-1:0] pick_symbol();
    if ($urandom_range(99) < 85) return alphabet[$urandom_range(alpha_len - 1)];
    return 8'($urandom_range(255));
  endfunction

  initial begin
    int unsigned r;
    rst_ni        = 1'b0;
    in_valid      = 1'b0;
    in_kind       = KindLoad;
    in_from_state = '0;
    in_symbol     = '0;
    in_to_state   = '0;
    out_stall     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CfgStartState;
    cfg_data      = '0;
    no_gaps       = 1'b0;
    stall_on      = 1'b0;
    burst_left    = 0;
    requests_sent = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, starting from reset values of both registers.
    send(KindLoad, 4'd0, 8'h00, 4'd15);
    send(KindLoad, 4'd15, 8'hFF, 4'd0);
    send(KindIgnored, 4'd15, 8'hFF, 4'd15);
    send(KindStep, 4'd0, 8'h00, 4'd0);      // before any restart, from state 0
    send(KindStep, 4'd15, 8'hFF, 4'd15);
    send(KindStep, 4'd0, 8'h5A, 4'd0);      // missing transition kills the machine
    send(KindStep, 4'd0, 8'h00, 4'd0);
    send(KindLoad, 4'd0, 8'hA5, 4'd10);     // loads still land while dead
    send(KindRestart, 4'd15, 8'hFF, 4'd15);
    send(KindStep, 4'd0, 8'hA5, 4'd0);
    send(KindLoad, 4'd10, 8'h3C, 4'd5);
    send(KindLoad, 4'd10, 8'h3C, 4'd6);     // the newer destination wins
    send(KindStep, 4'd0, 8'h3C, 4'd0);
    send(KindIgnored, 4'd0, 8'h00, 4'd0);
    drain();
    configure(4'd15, 4'd15);
    send(KindRestart, 4'd0, 8'h00, 4'd0);
    send(KindStep, 4'd0, 8'hFF, 4'd0);
    send(KindStep, 4'd0, 8'h00, 4'd0);
    send(KindStep, 4'd0, 8'h77, 4'd0);
    send(KindStep, 4'd0, 8'h00, 4'd0);

    // Random phases: a register setting, a batch of loads over a small alphabet,
    // then restarted walks through the table with some noise mixed in.
    while (requests_sent < RequestGoal) begin
      drain();
      no_gaps = ($urandom_range(3) == 0);
      r = $urandom_range(5);
      if (r == 0) configure(4'd0, 4'd15);
      else if (r == 1) configure(4'd15, 4'd0);
      else configure(4'($urandom_range(15)), 4'($urandom_range(15)));

      alpha_len = $urandom_range(3, 8);
      for (int k = 0; k < alpha_len; k++) begin
        r = $urandom_range(9);
        alphabet[k] = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(255));
      end
      for (int s = 0; s < StateCount; s++) begin
        for (int k = 0; k < alpha_len; k++) begin
          if ($urandom_range(99) < 80) begin
            send(KindLoad, 4'(s), alphabet[k], 4'($urandom_range(15)));
          end
        end
      end

      repeat ($urandom_range(4, 10)) begin
        send(KindRestart, 4'($urandom_range(15)), 8'($urandom_range(255)),
             4'($urandom_range(15)));
        repeat ($urandom_range(3, 30)) begin
          r = $urandom_range(99);
          if (r < 86) begin
            send(KindStep, 4'($urandom_range(15)), pick_symbol(), 4'($urandom_range(15)));
          end else if (r < 92) begin
            send(KindLoad, 4'($urandom_range(15)), pick_symbol(), 4'($urandom_range(15)));
          end else if (r < 96) begin
            send(KindIgnored, 4'($urandom_range(15)), 8'($urandom_range(255)),
                 4'($urandom_range(15)));
          end else begin
            send(KindRestart, 4'($urandom_range(15)), 8'($urandom_range(255)),
                 4'($urandom_range(15)));
          end
        end
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
